/* sv/psca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// psca_pkg
// Shared types, widths and helper functions of the send credit allocator.
// ============================================================================
package psca_pkg;

    // Field widths fixed by the item formats.
    localparam int LEN_W   = 16;
    localparam int CTR_W   = 11;
    localparam int CNT_W   = 11;
    localparam int IDX_W   = 10;
    localparam int TALLY_W = 8;
    localparam int RUN_W   = 20;
    localparam int PAY_W   = 17;

    // A block is 64 bytes.
    localparam int BLK_SHIFT = 6;
    localparam int BLK_ROUND = 63;

    // Register reset values.
    localparam logic [CNT_W-1:0]   TOTAL_RESET      = 11'd1024;
    localparam logic [TALLY_W-1:0] MAX_RESETS_RESET = 8'd4;
    localparam logic [TALLY_W-1:0] TALLY_MAX        = 8'd255;

    // Register file.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Remainder steps done in each front stage (high bits first).
    localparam int HI_STEPS = 6;
    localparam int LO_STEPS = CNT_W - HI_STEPS;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        REG_TOTAL_BLOCKS = 1'b0,
        REG_MAX_RESETS   = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_RES    = 2'd1,
        ST_DEV_ERR   = 2'd2,
        ST_NO_CREDIT = 2'd3
    } t_status;

    localparam logic [1:0] UNIT_OK        = 2'd0;
    localparam logic [1:0] UNIT_LINK_DOWN = 2'd1;
    localparam logic [1:0] UNIT_DEV_ERR   = 2'd2;
    localparam logic [1:0] UNIT_UNDEFINED = 2'd3;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [LEN_W-1:0] payload_length;
        logic             crc_attached;
        logic [CTR_W-1:0] credit_counter;
        logic             credit_halted;
        logic [1:0]       unit_state;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] start_block;
        logic [CNT_W-1:0] block_count;
        logic [CNT_W-1:0] available_after;
        logic             context_was_reset;
        logic             too_many_resets;
        logic             stall_event;
    } t_rsp;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic             mode;
        logic [CNT_W-1:0] nblks;
        logic [IDX_W-1:0] nred;
        logic [CTR_W-1:0] counter;
        logic             halted;
        logic [1:0]       unit;
    } t_work;

    // One step of a restoring remainder: shift in a bit, subtract the divisor
    // if it fits. The remainder stays below the divisor.
    function automatic logic [CNT_W-1:0] rem_step(
        input logic [CNT_W-1:0] rem,
        input logic             bit_in,
        input logic [CNT_W-1:0] divisor
    );
        logic [CNT_W:0] sh;
        logic [CNT_W:0] diff;
        begin
            sh   = {rem, bit_in};
            diff = sh - {1'b0, divisor};
            if (sh >= {1'b0, divisor}) begin
                rem_step = diff[CNT_W-1:0];
            end else begin
                rem_step = sh[CNT_W-1:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

/* sv/psca_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// psca_req_if
// Valid/ready channel carrying one send or poll request item.
// ============================================================================
interface psca_req_if;
    logic            valid;
    logic            ready;
    psca_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/psca_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// psca_rsp_if
// Valid/ready channel carrying one allocation result item.
// ============================================================================
interface psca_rsp_if;
    logic            valid;
    logic            ready;
    psca_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/pio_send_credit_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pio_send_credit_allocator
// Allocates 64-byte blocks of a send ring against returned hardware credits.
// ============================================================================
// Usage:
//   i_req carries one request item per handshake: a send (size and CRC flag)
//   or a credit poll, together with the live credit counter, halted status
//   and unit state. o_rsp returns exactly one result item per request, in
//   order: status, first granted block, block count, free blocks after the
//   step and the reset/fatal/stall flags.
//   Throughput is one item per cycle while o_rsp takes results and no ring
//   pointer re-reduction is running. Each request passes two front stages that
//   size it and reduce its block count modulo the ring, a two-entry queue, and
//   the back stage, which updates the ring state into the result register.
//   When o_rsp stalls, the result register holds, the queue and front fill,
//   and i_req.ready drops once every stage is full; nothing is lost.
//   The APB port holds total_blocks (address 0) and max_resets (address 4);
//   write them only while no item is in flight. A total_blocks write makes
//   the back stage re-reduce the ring pointer before it takes the next item.
//   Synchronous reset empties the pipeline and restores the full ring; no
//   clearing pass is needed.
// ============================================================================
module pio_send_credit_allocator #(
    parameter int MAX_BLOCKS    = 1024,
    parameter int COUNTER_BITS  = 11,
    parameter int CRC_BYTES     = 8,
    parameter int RESYNC_PERIOD = 16,
    parameter int STALL_PERIOD  = 1048576
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    psca_req_if.sink                         i_req,
    psca_rsp_if.source                       o_rsp,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [psca_pkg::APB_AW-1:0]      paddr,
    input  wire  [psca_pkg::APB_DW-1:0]      pwdata,
    output logic [psca_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    localparam logic [psca_pkg::CNT_W-1:0] MAX_TOTAL = psca_pkg::CNT_W'(MAX_BLOCKS);

    logic [psca_pkg::CNT_W-1:0]    r_total_blocks;
    logic [psca_pkg::TALLY_W-1:0]  r_max_resets;
    logic [psca_pkg::CNT_W-1:0]    eff_total;
    psca_pkg::t_reg_idx            reg_idx;
    logic                          cfg_wr;
    logic                          total_wr;

    logic                          work_valid;
    logic                          work_ready;
    psca_pkg::t_work               work;
    logic                          q_valid;
    logic                          q_ready;
    psca_pkg::t_work               q_work;

    // Register decode: one 32-bit word per register.
    assign pready   = 1'b1;
    assign reg_idx  = psca_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign total_wr = cfg_wr && (reg_idx == psca_pkg::REG_TOTAL_BLOCKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_blocks <= psca_pkg::TOTAL_RESET;
            r_max_resets   <= psca_pkg::MAX_RESETS_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                psca_pkg::REG_TOTAL_BLOCKS: r_total_blocks <= pwdata[psca_pkg::CNT_W-1:0];
                psca_pkg::REG_MAX_RESETS:   r_max_resets   <= pwdata[psca_pkg::TALLY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            psca_pkg::REG_TOTAL_BLOCKS:
                prdata = psca_pkg::APB_DW'(r_total_blocks);
            psca_pkg::REG_MAX_RESETS:
                prdata = psca_pkg::APB_DW'(r_max_resets);
            default:
                prdata = '0;
        endcase
    end

    // Ring size in use: at least one block, at most the ring capacity.
    always_comb begin
        if (r_total_blocks == '0) begin
            eff_total = psca_pkg::CNT_W'(1);
        end else if (r_total_blocks > MAX_TOTAL) begin
            eff_total = MAX_TOTAL;
        end else begin
            eff_total = r_total_blocks;
        end
    end

    psca_front #(
        .CRC_BYTES (CRC_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_eff_total  (eff_total),
        .o_work_valid (work_valid),
        .i_work_ready (work_ready),
        .o_work       (work)
    );

    psca_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (work_valid),
        .o_push_ready (work_ready),
        .i_push_data  (work),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_work)
    );

    psca_back #(
        .MAX_BLOCKS    (MAX_BLOCKS),
        .COUNTER_BITS  (COUNTER_BITS),
        .RESYNC_PERIOD (RESYNC_PERIOD),
        .STALL_PERIOD  (STALL_PERIOD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (q_valid),
        .o_work_ready (q_ready),
        .i_work       (q_work),
        .i_eff_total  (eff_total),
        .i_max_resets (r_max_resets),
        .i_total_wr   (total_wr),
        .o_rsp        (o_rsp)
    );

endmodule
`default_nettype wire

/* sv/psca_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// psca_front
// Accepts request items, sizes them in blocks and reduces the block count
// modulo the ring size over two pipeline stages.
// ============================================================================
module psca_front #(
    parameter int CRC_BYTES = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    psca_req_if.sink                     i_req,
    input  wire  [psca_pkg::CNT_W-1:0]   i_eff_total,
    output logic                         o_work_valid,
    input  wire                          i_work_ready,
    output psca_pkg::t_work              o_work
);

    logic                         s1_go;
    logic                         s2_go;
    logic [psca_pkg::PAY_W-1:0]   paylen;
    logic [psca_pkg::PAY_W-1:0]   blk_sum;
    logic [psca_pkg::CNT_W-1:0]   nblks;
    logic [psca_pkg::CNT_W-1:0]   rem_hi;
    logic [psca_pkg::CNT_W-1:0]   rem_lo;
    psca_pkg::t_work              n_s2_work;

    logic                         r_s1_valid;
    psca_pkg::t_req               r_s1_req;
    logic [psca_pkg::CNT_W-1:0]   r_s1_nblks;
    logic [psca_pkg::CNT_W-1:0]   r_s1_rem;
    logic                         r_s2_valid;
    psca_pkg::t_work              r_s2_work;

    // Stages advance when the one after them is empty or moving.
    assign s2_go       = !r_s2_valid || i_work_ready;
    assign s1_go       = !r_s1_valid || s2_go;
    assign i_req.ready = s1_go;

    // Header block plus the payload rounded up to whole blocks.
    always_comb begin
        paylen  = psca_pkg::PAY_W'(i_req.data.payload_length)
                + (i_req.data.crc_attached ? psca_pkg::PAY_W'(CRC_BYTES)
                                           : psca_pkg::PAY_W'(0));
        blk_sum = ((paylen + psca_pkg::PAY_W'(psca_pkg::BLK_ROUND)) >> psca_pkg::BLK_SHIFT)
                + psca_pkg::PAY_W'(1);
        nblks   = blk_sum[psca_pkg::CNT_W-1:0];
    end

    // High bits of the remainder of the block count by the ring size.
    always_comb begin
        rem_hi = '0;
        for (int i = 0; i < psca_pkg::HI_STEPS; i++) begin
            rem_hi = psca_pkg::rem_step(rem_hi, nblks[psca_pkg::CNT_W-1-i], i_eff_total);
        end
    end

    // Low bits finish the remainder in the second stage.
    always_comb begin
        rem_lo = r_s1_rem;
        for (int i = 0; i < psca_pkg::LO_STEPS; i++) begin
            rem_lo = psca_pkg::rem_step(rem_lo, r_s1_nblks[psca_pkg::LO_STEPS-1-i],
                                        i_eff_total);
        end
        n_s2_work.mode    = r_s1_req.mode;
        n_s2_work.nblks   = r_s1_nblks;
        n_s2_work.nred    = rem_lo[psca_pkg::IDX_W-1:0];
        n_s2_work.counter = r_s1_req.credit_counter;
        n_s2_work.halted  = r_s1_req.credit_halted;
        n_s2_work.unit    = r_s1_req.unit_state;
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_s1_valid <= i_req.valid;
            end
            if (s2_go) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (s1_go && i_req.valid) begin
            r_s1_req   <= i_req.data;
            r_s1_nblks <= nblks;
            r_s1_rem   <= rem_hi;
        end
        if (s2_go && r_s1_valid) begin
            r_s2_work <= n_s2_work;
        end
    end

    assign o_work_valid = r_s2_valid;
    assign o_work       = r_s2_work;

endmodule
`default_nettype wire

/* sv/psca_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// psca_queue
// Short FIFO that decouples the classifying front from the allocating back.
// ============================================================================
module psca_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push_valid,
    output logic             o_push_ready,
    input  psca_pkg::t_work  i_push_data,
    output logic             o_pop_valid,
    input  wire              i_pop_ready,
    output psca_pkg::t_work  o_pop_data
);

    // Depth is a power of two so the pointers wrap by themselves.
    localparam int DEPTH = psca_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psca_pkg::t_work    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

/* sv/psca_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// psca_back
// Holds the ring and credit state, grants or refuses each item and drives
// the result register. Re-reduces the ring pointer after a size change.
// ============================================================================
module psca_back #(
    parameter int MAX_BLOCKS    = 1024,
    parameter int COUNTER_BITS  = 11,
    parameter int RESYNC_PERIOD = 16,
    parameter int STALL_PERIOD  = 1048576
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_work_valid,
    output logic                           o_work_ready,
    input  psca_pkg::t_work                i_work,
    input  wire  [psca_pkg::CNT_W-1:0]     i_eff_total,
    input  wire  [psca_pkg::TALLY_W-1:0]   i_max_resets,
    input  wire                            i_total_wr,
    psca_rsp_if.source                     o_rsp
);

    localparam int CB = COUNTER_BITS;
    localparam int UW = (COUNTER_BITS > psca_pkg::CTR_W) ? COUNTER_BITS : psca_pkg::CTR_W;
    localparam int RESET_FREE_I = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;
    localparam logic [psca_pkg::CNT_W-1:0] RESET_FREE = psca_pkg::CNT_W'(RESET_FREE_I);
    localparam logic [psca_pkg::RUN_W-1:0] RESYNC_MASK = psca_pkg::RUN_W'(RESYNC_PERIOD - 1);
    localparam logic [psca_pkg::RUN_W-1:0] STALL_MASK  = psca_pkg::RUN_W'(STALL_PERIOD - 1);
    localparam int RIDX_W = $clog2(psca_pkg::IDX_W);

    // Allocation state.
    logic [psca_pkg::CNT_W-1:0]    r_free_blocks;
    logic [psca_pkg::IDX_W-1:0]    r_next_block;
    logic [psca_pkg::IDX_W-1:0]    r_next_red;
    logic [CB-1:0]                 r_fill_count;
    logic [CB-1:0]                 r_seen_counter;
    logic                          r_seen_halted;
    logic [psca_pkg::TALLY_W-1:0]  r_reset_tally;
    logic [psca_pkg::RUN_W-1:0]    r_failure_run;

    // Pointer reduction after a ring size change.
    logic                          r_busy;
    logic [RIDX_W-1:0]             r_red_idx;
    logic [psca_pkg::CNT_W-1:0]    r_red_acc;
    logic [psca_pkg::CNT_W-1:0]    red_step;

    // Result register.
    logic                          r_out_valid;
    psca_pkg::t_rsp                r_out;

    // Step logic.
    logic                          pop;
    logic [CB-1:0]                 ctr_m;
    logic                          differs;
    logic [CB-1:0]                 used;
    logic [psca_pkg::CNT_W-1:0]    free_upd;
    logic [psca_pkg::TALLY_W-1:0]  tally_inc1;
    logic [psca_pkg::TALLY_W-1:0]  tally_inc2;
    logic                          short_before;
    logic                          upd1;
    logic                          reset1;
    logic                          upd2;
    logic [psca_pkg::CNT_W-1:0]    free1;
    logic                          refuse;
    logic [psca_pkg::RUN_W-1:0]    run_inc;
    logic                          stall;
    logic [psca_pkg::CNT_W-1:0]    ptr_sum;
    logic [psca_pkg::CNT_W-1:0]    ptr_base;

    logic [psca_pkg::CNT_W-1:0]    n_free_blocks;
    logic [psca_pkg::IDX_W-1:0]    n_next_block;
    logic [psca_pkg::IDX_W-1:0]    n_next_red;
    logic [CB-1:0]                 n_fill_count;
    logic [CB-1:0]                 n_seen_counter;
    logic                          n_seen_halted;
    logic [psca_pkg::TALLY_W-1:0]  n_reset_tally;
    logic [psca_pkg::RUN_W-1:0]    n_failure_run;
    psca_pkg::t_rsp                n_out;

    assign pop          = i_work_valid && o_work_ready;
    assign o_work_ready = !r_busy && (!r_out_valid || o_rsp.ready);

    // Credit update terms shared by every call site.
    always_comb begin
        ctr_m      = CB'(UW'(i_work.counter));
        differs    = (ctr_m != r_seen_counter) || (i_work.halted != r_seen_halted);
        used       = r_fill_count - ctr_m;
        free_upd   = (UW'(used) > UW'(i_eff_total))
                   ? '0 : psca_pkg::CNT_W'(UW'(i_eff_total) - UW'(used));
        tally_inc1 = (r_reset_tally == psca_pkg::TALLY_MAX)
                   ? r_reset_tally : r_reset_tally + 8'd1;
        tally_inc2 = (tally_inc1 == psca_pkg::TALLY_MAX) ? tally_inc1 : tally_inc1 + 8'd1;
    end

    // Decide grant, refusal or poll for the item at the head of the queue.
    always_comb begin
        short_before = (r_free_blocks < i_work.nblks);
        upd1   = differs && ((i_work.mode == psca_pkg::MODE_POLL) || short_before);
        reset1 = upd1 && i_work.halted;
        if (reset1) begin
            free1 = i_eff_total;
        end else if (upd1) begin
            free1 = free_upd;
        end else begin
            free1 = r_free_blocks;
        end
        refuse  = (i_work.mode == psca_pkg::MODE_SEND) && (free1 < i_work.nblks);
        run_inc = r_failure_run + psca_pkg::RUN_W'(1);
        stall   = refuse && (i_work.unit == psca_pkg::UNIT_OK)
               && ((run_inc & RESYNC_MASK) == '0) && ((run_inc & STALL_MASK) == '0);
        // A retried update only acts on a halted status: the seen pair already
        // matches a live counter, and a halted reset leaves it cleared.
        upd2 = stall && i_work.halted;

        // New ring pointer: reduced base plus reduced block count, one wrap.
        ptr_base = reset1 ? '0 : psca_pkg::CNT_W'(r_next_red);
        ptr_sum  = ptr_base + psca_pkg::CNT_W'(i_work.nblks == '0 ? '0 : i_work.nred);
        if (ptr_sum >= i_eff_total) begin
            ptr_sum = ptr_sum - i_eff_total;
        end

        // Defaults: state follows the credit update only.
        n_free_blocks  = free1;
        n_next_block   = reset1 ? '0 : r_next_block;
        n_next_red     = reset1 ? '0 : r_next_red;
        n_fill_count   = reset1 ? '0 : r_fill_count;
        n_seen_counter = r_seen_counter;
        n_seen_halted  = r_seen_halted;
        n_reset_tally  = r_reset_tally;
        n_failure_run  = r_failure_run;

        if (upd1) begin
            // After a halt the hardware shows a clear counter and status.
            n_seen_counter = reset1 ? '0 : ctr_m;
            n_seen_halted  = 1'b0;
            if (reset1) begin
                n_reset_tally = upd2 ? tally_inc2 : tally_inc1;
            end else begin
                n_reset_tally = '0;
            end
        end

        n_out.status            = psca_pkg::ST_OK;
        n_out.start_block       = '0;
        n_out.block_count       = '0;
        n_out.context_was_reset = reset1;
        n_out.too_many_resets   = reset1 && (n_reset_tally > i_max_resets);
        n_out.stall_event       = stall;

        if (i_work.mode == psca_pkg::MODE_POLL) begin
            n_out.status = differs ? psca_pkg::ST_OK : psca_pkg::ST_NO_CREDIT;
        end else if (refuse) begin
            n_out.block_count = i_work.nblks;
            if (i_work.unit == psca_pkg::UNIT_OK) begin
                n_failure_run = run_inc;
                n_out.status  = psca_pkg::ST_NO_RES;
            end else if (i_work.unit == psca_pkg::UNIT_LINK_DOWN) begin
                n_out.status  = psca_pkg::ST_NO_RES;
            end else begin
                n_out.status  = psca_pkg::ST_DEV_ERR;
            end
        end else begin
            n_out.block_count = i_work.nblks;
            n_out.start_block = reset1 ? '0 : r_next_block;
            n_free_blocks     = free1 - i_work.nblks;
            n_fill_count      = (reset1 ? '0 : r_fill_count) + CB'(UW'(i_work.nblks));
            n_next_block      = ptr_sum[psca_pkg::IDX_W-1:0];
            n_next_red        = ptr_sum[psca_pkg::IDX_W-1:0];
            n_failure_run     = '0;
        end
        n_out.available_after = n_free_blocks;
    end

    // Allocation state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_blocks  <= RESET_FREE;
            r_next_block   <= '0;
            r_fill_count   <= '0;
            r_seen_counter <= '0;
            r_seen_halted  <= 1'b0;
            r_reset_tally  <= '0;
            r_failure_run  <= '0;
        end else if (pop) begin
            r_free_blocks  <= n_free_blocks;
            r_next_block   <= n_next_block;
            r_fill_count   <= n_fill_count;
            r_seen_counter <= n_seen_counter;
            r_seen_halted  <= n_seen_halted;
            r_reset_tally  <= n_reset_tally;
            r_failure_run  <= n_failure_run;
        end
    end

    // Reduced pointer: one remainder bit per cycle after a size change.
    assign red_step = psca_pkg::rem_step(r_red_acc, r_next_block[r_red_idx], i_eff_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_red_idx  <= '0;
            r_red_acc  <= '0;
            r_next_red <= '0;
        end else if (i_total_wr) begin
            r_busy    <= 1'b1;
            r_red_idx <= RIDX_W'(psca_pkg::IDX_W - 1);
            r_red_acc <= '0;
        end else if (r_busy) begin
            r_red_acc <= red_step;
            r_red_idx <= r_red_idx - RIDX_W'(1);
            if (r_red_idx == '0) begin
                r_busy     <= 1'b0;
                r_next_red <= red_step[psca_pkg::IDX_W-1:0];
            end
        end else if (pop) begin
            r_next_red <= n_next_red;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

`ifndef SYNTHESIS
    // The reduced pointer stays inside the ring whenever items may be taken.
    a_red_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (psca_pkg::CNT_W'(r_next_red) < i_eff_total))
        else $error("reduced ring pointer out of range");

    // A stall event only comes with a refusal for lack of blocks.
    a_stall_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stall_event) |-> (r_out.status == psca_pkg::ST_NO_RES))
        else $error("stall event on a non-refused item");

    // The fatal flag is raised only by a ring reset.
    a_fatal_on_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.too_many_resets) |-> r_out.context_was_reset)
        else $error("fatal flag without a ring reset");

    // Free block count and fill count hold while the pointer is being reduced.
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> ($stable(r_free_blocks) && $stable(r_fill_count)))
        else $error("allocation state changed during pointer reduction");
`endif

endmodule
`default_nettype wire

/* tb/tb_pio_send_credit_allocator.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_pio_send_credit_allocator
// Self-checking bench for the send credit allocator. A queue-fed driver
// presents send and poll items in random bursts, a clocked monitor predicts
// every result from its own copy of the ring state and compares it field by
// field, and the ring size and reset limit are changed between phases over
// the APB port while the block is idle.
// ============================================================================
module tb_pio_send_credit_allocator;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 90;
    localparam int N_PHASES     = 7;
    localparam int QUEUE_AHEAD  = 4;
    localparam int BYTES_W      = psca_pkg::PAY_W + 1;

    // Block parameters, as instantiated with their defaults.
    localparam int RING_MAX = 1024;
    localparam int CRC_LEN  = 8;
    localparam logic [psca_pkg::RUN_W-1:0] RESYNC_MASK = psca_pkg::RUN_W'(16 - 1);
    localparam logic [psca_pkg::RUN_W-1:0] STALL_MASK  = psca_pkg::RUN_W'((1 << 20) - 1);

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_style;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [psca_pkg::APB_AW-1:0] paddr;
    logic [psca_pkg::APB_DW-1:0] pwdata;
    logic [psca_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    psca_req_if req_if ();
    psca_rsp_if rsp_if ();

    pio_send_credit_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the allocator registers and ring state.
    logic [psca_pkg::CNT_W-1:0]   cfg_total;
    logic [psca_pkg::TALLY_W-1:0] cfg_max_resets;
    logic [psca_pkg::CNT_W-1:0]   ring_free;
    logic [psca_pkg::IDX_W-1:0]   ring_next;
    logic [psca_pkg::CTR_W-1:0]   ring_fill;
    logic [psca_pkg::CTR_W-1:0]   seen_ctr;
    logic                         seen_halt;
    logic [psca_pkg::TALLY_W-1:0] reset_tally;
    logic [psca_pkg::RUN_W-1:0]   failure_run;
    logic                         step_was_reset;
    logic                         step_fatal;

    // Request items waiting to be sent and results still owed by the block.
    psca_pkg::t_req pending_reqs[$];
    psca_pkg::t_rsp awaited_results[$];

    // Stimulus generator state: the credit counter the hardware would show.
    logic [psca_pkg::CTR_W-1:0] hw_credit = '0;
    int                         halt_storm = 0;

    // Handshake and pacing state.
    logic      req_fire = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        bursts_started = 0;
    logic      drain_hold = 1'b0;
    t_rx_style rx_style = RX_OPEN;
    int        rx_window = 0;

    int cycle_count = 0;
    int failures = 0;
    int n_checked = 0;
    int n_ok = 0;
    int n_refused = 0;
    int n_dev_err = 0;
    int n_no_credit = 0;
    int n_resets = 0;
    int n_fatal = 0;

    // Ring size in use: zero counts as one, anything above the maximum is capped.
    function automatic logic [psca_pkg::CNT_W-1:0] ring_size();
        logic [psca_pkg::CNT_W-1:0] size;
        size = cfg_total;
        if (size == '0) size = psca_pkg::CNT_W'(1);
        if (size > psca_pkg::CNT_W'(RING_MAX)) size = psca_pkg::CNT_W'(RING_MAX);
        return size;
    endfunction

    // Applies the hardware credit status; returns 1 when it differs from the
    // last one seen. A halted status empties the ring and counts a reset.
    function automatic logic apply_credits(logic [psca_pkg::CTR_W-1:0] ctr, logic halted);
        logic [psca_pkg::CNT_W-1:0] size;
        logic [psca_pkg::CTR_W-1:0] used;
        size = ring_size();
        if (ctr == seen_ctr && halted == seen_halt) return 1'b0;
        if (halted) begin
            if (reset_tally != psca_pkg::TALLY_MAX) reset_tally = reset_tally + 1'b1;
            if (reset_tally > cfg_max_resets) step_fatal = 1'b1;
            step_was_reset = 1'b1;
            ring_free = size;
            ring_next = '0;
            ring_fill = '0;
            seen_ctr = '0;
            seen_halt = 1'b0;
        end else begin
            seen_ctr = ctr;
            seen_halt = halted;
            used = ring_fill - ctr;
            ring_free = (used > size) ? '0 : size - used;
            reset_tally = '0;
        end
        return 1'b1;
    endfunction

    // Works out the result of one request item and advances the shadow state.
    function automatic psca_pkg::t_rsp predict_allocation(psca_pkg::t_req rq);
        psca_pkg::t_rsp               rsp;
        logic [BYTES_W-1:0]           bytes;
        logic [psca_pkg::CNT_W-1:0]   nblks;
        logic [psca_pkg::CNT_W+1:0]   next_sum;
        logic                         stall;
        rsp = '0;
        nblks = '0;
        stall = 1'b0;
        step_was_reset = 1'b0;
        step_fatal = 1'b0;
        if (rq.mode == psca_pkg::MODE_POLL) begin
            rsp.status = apply_credits(rq.credit_counter, rq.credit_halted) ?
                         psca_pkg::ST_OK : psca_pkg::ST_NO_CREDIT;
        end else begin
            bytes = BYTES_W'(rq.payload_length)
                  + (rq.crc_attached ? BYTES_W'(CRC_LEN) : BYTES_W'(0));
            nblks = psca_pkg::CNT_W'(1 + ((bytes + psca_pkg::BLK_ROUND) >> psca_pkg::BLK_SHIFT));
            if (ring_free < nblks) void'(apply_credits(rq.credit_counter, rq.credit_halted));
            if (ring_free < nblks) begin
                if (rq.unit_state == psca_pkg::UNIT_OK) begin
                    failure_run = failure_run + 1'b1;
                    if ((failure_run & RESYNC_MASK) == '0 &&
                        (failure_run & STALL_MASK) == '0) begin
                        stall = 1'b1;
                        void'(apply_credits(rq.credit_counter, rq.credit_halted));
                    end
                    rsp.status = psca_pkg::ST_NO_RES;
                end else if (rq.unit_state == psca_pkg::UNIT_LINK_DOWN) begin
                    rsp.status = psca_pkg::ST_NO_RES;
                end else begin
                    rsp.status = psca_pkg::ST_DEV_ERR;
                end
            end else begin
                rsp.start_block = ring_next;
                ring_free = ring_free - nblks;
                ring_fill = ring_fill + nblks;
                next_sum = ring_next + nblks;
                ring_next = psca_pkg::IDX_W'(next_sum % ring_size());
                failure_run = '0;
                rsp.status = psca_pkg::ST_OK;
            end
        end
        rsp.block_count = nblks;
        rsp.available_after = ring_free;
        rsp.context_was_reset = step_was_reset;
        rsp.too_many_resets = step_fatal;
        rsp.stall_event = stall;
        return rsp;
    endfunction

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    // Monitor: checks result items, then predicts for the request taken now.
    always @(posedge i_clk) begin
        psca_pkg::t_rsp want;
        cycle_count++;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result item with none expected: status %0d, count %0d",
                           rsp_if.data.status, rsp_if.data.block_count);
                    failures++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, rsp_if.data.status);
                    check_field("start_block", want.start_block, rsp_if.data.start_block);
                    check_field("block_count", want.block_count, rsp_if.data.block_count);
                    check_field("available_after", want.available_after,
                                rsp_if.data.available_after);
                    check_field("context_was_reset", want.context_was_reset,
                                rsp_if.data.context_was_reset);
                    check_field("too_many_resets", want.too_many_resets,
                                rsp_if.data.too_many_resets);
                    check_field("stall_event", want.stall_event, rsp_if.data.stall_event);
                    n_checked++;
                    case (want.status)
                        psca_pkg::ST_OK:        n_ok++;
                        psca_pkg::ST_NO_RES:    n_refused++;
                        psca_pkg::ST_DEV_ERR:   n_dev_err++;
                        psca_pkg::ST_NO_CREDIT: n_no_credit++;
                        default:                n_no_credit += 0;
                    endcase
                    if (want.context_was_reset) n_resets++;
                    if (want.too_many_resets) n_fatal++;
                end
            end
            req_fire = req_if.valid && req_if.ready;
            if (req_fire) awaited_results.push_back(predict_allocation(req_if.data));
        end else begin
            req_fire = 1'b0;
        end
    end

    // Driver: bursts of items with random gaps, and now and then a pause
    // until the block has returned every result it owes.
    always @(negedge i_clk) begin
        logic           drive_valid;
        psca_pkg::t_req drive_data;
        drive_valid = 1'b0;
        drive_data = req_if.data;
        if (i_rst_n) begin
            if (req_fire) begin
                pending_reqs.delete(0);
                if (burst_left > 0) burst_left--;
            end
            if (req_if.valid && !req_fire) begin
                drive_valid = 1'b1;
            end else if (pending_reqs.size() > 0) begin
                if (burst_left == 0 && gap_left == 0 && !drain_hold) begin
                    bursts_started++;
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = $urandom_range(1, 3);
                        1:       gap_left = $urandom_range(4, 30);
                        default: gap_left = 0;
                    endcase
                    drain_hold = (bursts_started == 6) || ($urandom_range(0, 39) == 0);
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (drain_hold) begin
                    if (awaited_results.size() == 0) drain_hold = 1'b0;
                end else begin
                    drive_valid = 1'b1;
                    drive_data = pending_reqs[0];
                end
            end
        end
        req_if.valid <= drive_valid;
        req_if.data <= drive_data;
    end

    // Receiver: the stall pattern changes from one random window to the next.
    always @(negedge i_clk) begin
        logic take;
        take = 1'b0;
        if (i_rst_n) begin
            if (rx_window == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 3));
                rx_window = $urandom_range(40, 300);
            end
            rx_window--;
            case (rx_style)
                RX_OPEN:     take = 1'b1;
                RX_RANDOM:   take = ($urandom_range(0, 3) != 0);
                RX_PERIODIC: take = (rx_window % 5 > 1);
                default:     take = ($urandom_range(0, 7) == 0);
            endcase
        end
        rsp_if.ready <= take;
    end

    function automatic logic [psca_pkg::APB_AW-1:0] reg_addr(psca_pkg::t_reg_idx idx);
        return psca_pkg::APB_AW'({idx, 2'b00});
    endfunction

    task automatic cfg_write(psca_pkg::t_reg_idx idx, logic [psca_pkg::APB_DW-1:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = reg_addr(idx);
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == psca_pkg::REG_TOTAL_BLOCKS) cfg_total = value[psca_pkg::CNT_W-1:0];
        else cfg_max_resets = value[psca_pkg::TALLY_W-1:0];
    endtask

    task automatic cfg_readback(psca_pkg::t_reg_idx idx, string field,
                                logic [psca_pkg::APB_DW-1:0] want);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = reg_addr(idx);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field(field, want, prdata);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic add_item(logic mode, int len, logic crc, int ctr, logic halted,
                            logic [1:0] unit);
        psca_pkg::t_req rq;
        rq.mode = mode;
        rq.payload_length = psca_pkg::LEN_W'(len);
        rq.crc_attached = crc;
        rq.credit_counter = psca_pkg::CTR_W'(ctr);
        rq.credit_halted = halted;
        rq.unit_state = unit;
        pending_reqs.push_back(rq);
    endtask

    // Random item that follows the ring: the credit counter trails the fill
    // count the way returned credits would, with some noise and halt storms.
    function automatic psca_pkg::t_req next_random_item();
        psca_pkg::t_req             rq;
        logic [psca_pkg::CTR_W-1:0] lag;
        rq = '0;
        lag = ring_fill - hw_credit;
        if (lag > ring_size()) begin
            hw_credit = ring_fill;
        end else if ($urandom_range(0, 2) == 0) begin
            hw_credit = hw_credit + psca_pkg::CTR_W'($urandom_range(0, lag));
        end
        rq.credit_counter = ($urandom_range(0, 19) == 0) ? psca_pkg::CTR_W'($urandom)
                                                          : hw_credit;
        if (halt_storm == 0 && $urandom_range(0, 59) == 0) halt_storm = $urandom_range(1, 7);
        if (halt_storm > 0) begin
            halt_storm--;
            rq.mode = psca_pkg::MODE_POLL;
            rq.credit_halted = 1'b1;
        end else begin
            rq.mode = ($urandom_range(0, 5) == 0) ? psca_pkg::MODE_POLL : psca_pkg::MODE_SEND;
            rq.credit_halted = ($urandom_range(0, 39) == 0);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: rq.payload_length = psca_pkg::LEN_W'(4 * $urandom_range(0, 256));
            5:             rq.payload_length = psca_pkg::LEN_W'(4 * $urandom_range(0, 16383));
            6:             rq.payload_length = psca_pkg::LEN_W'($urandom);
            7: begin
                case ($urandom_range(0, 3))
                    0:       rq.payload_length = '0;
                    1:       rq.payload_length = psca_pkg::LEN_W'(65532);
                    2:       rq.payload_length = '1;
                    default: rq.payload_length = psca_pkg::LEN_W'(64);
                endcase
            end
            default:       rq.payload_length = psca_pkg::LEN_W'(4 * $urandom_range(0, 31));
        endcase
        rq.crc_attached = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
            16, 17:  rq.unit_state = psca_pkg::UNIT_LINK_DOWN;
            18:      rq.unit_state = psca_pkg::UNIT_DEV_ERR;
            19:      rq.unit_state = psca_pkg::UNIT_UNDEFINED;
            default: rq.unit_state = psca_pkg::UNIT_OK;
        endcase
        return rq;
    endfunction

    task automatic queue_random_items(int count);
        repeat (count) begin
            while (pending_reqs.size() >= QUEUE_AHEAD) @(negedge i_clk);
            pending_reqs.push_back(next_random_item());
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || awaited_results.size() != 0 || req_if.valid)
            @(negedge i_clk);
    endtask

    // Watchdog on the cycle counter.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("pio_send_credit_allocator verification failed");
        $finish;
    end

    // Sequencer: reset, directed items, then one random phase per setting.
    initial begin
        int unsigned set_total;
        int unsigned set_limit;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        cfg_total = psca_pkg::TOTAL_RESET;
        cfg_max_resets = psca_pkg::MAX_RESETS_RESET;
        ring_free = psca_pkg::TOTAL_RESET;
        ring_next = '0;
        ring_fill = '0;
        seen_ctr = '0;
        seen_halt = 1'b0;
        reset_tally = '0;
        failure_run = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items at the reset setting.
        // Nothing new to see, then a header block only and a CRC spilling a block.
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 0, 1'b0, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_SEND, 0, 1'b0, 0, 1'b0, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_SEND, 0, 1'b1, 0, 1'b0, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_SEND, 64, 1'b0, 0, 1'b0, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_SEND, 60, 1'b1, 0, 1'b0, psca_pkg::UNIT_OK);
        // Requests larger than the ring under each unit state.
        add_item(psca_pkg::MODE_SEND, 65532, 1'b1, 0, 1'b0, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_SEND, 65535, 1'b0, 0, 1'b0, psca_pkg::UNIT_LINK_DOWN);
        add_item(psca_pkg::MODE_SEND, 65535, 1'b1, 0, 1'b0, psca_pkg::UNIT_DEV_ERR);
        add_item(psca_pkg::MODE_SEND, 65535, 1'b1, 0, 1'b0, psca_pkg::UNIT_UNDEFINED);
        // All credits back, then the whole ring taken so the pointer wraps.
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 8, 1'b0, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_SEND, 65468, 1'b0, 8, 1'b0, psca_pkg::UNIT_OK);
        // Ring full with stale credits, then fresh credits allow a grant.
        add_item(psca_pkg::MODE_SEND, 0, 1'b0, 8, 1'b0, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_SEND, 0, 1'b0, 1032, 1'b0, psca_pkg::UNIT_OK);
        // Outstanding count above the total.
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 2047, 1'b0, psca_pkg::UNIT_OK);
        // Halted status: ring resets until past the reset limit.
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 0, 1'b1, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 2047, 1'b1, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 0, 1'b1, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 0, 1'b1, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 0, 1'b1, psca_pkg::UNIT_OK);
        // Post-reset view, then a good update that clears the tally.
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 0, 1'b0, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_POLL, 0, 1'b0, 5, 1'b0, psca_pkg::UNIT_OK);
        // Halt seen inside a send.
        add_item(psca_pkg::MODE_SEND, 4, 1'b0, 0, 1'b1, psca_pkg::UNIT_OK);
        add_item(psca_pkg::MODE_SEND, 128, 1'b1, 0, 1'b0, psca_pkg::UNIT_OK);
        wait_idle();

        // Random phases over several ring sizes and reset limits.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin set_total = 16;   set_limit = 0;   end
                1: begin set_total = 1;    set_limit = 255; end
                2: begin set_total = 0;    set_limit = 1;   end
                3: begin set_total = 2047; set_limit = 4;   end
                4: begin set_total = 1024; set_limit = 255; end
                5: begin
                    set_total = $urandom_range(2, 1023);
                    set_limit = $urandom_range(0, 255);
                end
                default: begin set_total = 48; set_limit = 2; end
            endcase
            cfg_write(psca_pkg::REG_TOTAL_BLOCKS, set_total);
            cfg_write(psca_pkg::REG_MAX_RESETS, set_limit);
            cfg_readback(psca_pkg::REG_TOTAL_BLOCKS, "total_blocks", set_total);
            cfg_readback(psca_pkg::REG_MAX_RESETS, "max_resets", set_limit);
            queue_random_items(PHASE_ITEMS);
            wait_idle();
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d result items over %0d ring settings: %0d granted or updated,",
                 n_checked, N_PHASES + 1, n_ok);
        $display("%0d refused, %0d device errors, %0d idle polls, %0d ring resets (%0d fatal).",
                 n_refused, n_dev_err, n_no_credit, n_resets, n_fatal);
        if (failures == 0) begin
            $display("pio_send_credit_allocator verification clean");
        end else begin
            $display("pio_send_credit_allocator verification failed");
        end
        $finish;
    end

endmodule
